### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sfp_pkg.sv
// Types and constants of the serial command frame parser.
package sfp_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 256;
  localparam int unsigned TimeoutW = 10;
  localparam int unsigned CountW = 9;
  localparam int unsigned FieldW = 2;
  localparam int unsigned ByteW = 8;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 10'd100;
  localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CHAR_BANG = 8'h21;
  localparam logic [ByteW-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [FieldW-1:0] FIELD_DATA = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CHAR    = 3'd1,
    EV_START   = 3'd2,
    EV_FIELD   = 3'd3,
    EV_DONE    = 3'd4,
    EV_TIMEOUT = 3'd5,
    EV_IGNORED = 3'd6
  } event_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                in_packet;
    logic [FieldW-1:0]   current_field;
    logic [CountW-1:0]   char_count;
    logic [TimeoutW-1:0] timeout_left;
  } sfp_state_t;

  typedef struct packed {
    event_t              event_res;
    logic [FieldW-1:0]   field_index;
    logic [CountW-1:0]   char_position;
    logic [ByteW-1:0]    char_value;
  } sfp_result_t;

endpackage

### design/sfp_cmd_if.sv
// Input channel carrying received bytes and millisecond ticks.
interface sfp_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### design/sfp_res_if.sv
// Output channel carrying parser events.
interface sfp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] field_index;
  logic [8:0] char_position;
  logic [7:0] char_value;

  modport source (
    output valid, output event_res, output field_index, output char_position,
    output char_value, input ready
  );
  modport sink (
    input valid, input event_res, input field_index, input char_position,
    input char_value, output ready
  );
endinterface

### design/serial_command_frame_parser.sv
// Top level of the serial command frame parser.
// The cmd channel takes one beat per item: opcode 0 carries a received byte in
// rx_byte, opcode 1 marks one millisecond tick. Every accepted beat yields
// exactly one beat on the result channel with an event code, the field, the
// character position or field length, and the stored character.
// Packets have the form ':command,length,data!' and are tracked by a small
// state register that is updated at the edge where a cmd beat is accepted.
// The result of a beat is held in an output register and appears in the cycle
// after acceptance. A new cmd beat is accepted every cycle while the result
// register is empty or is being taken in the same cycle, so the sustained
// rate is one item per cycle, set by the single result register.
// When the receiver stalls, the result is held and cmd stops after one beat.
// The user must write the idle timeout register via cfg_we and cfg_data only
// while the block is idle; the block does not enforce it. Reset clears the
// packet state and result register and sets the timeout register to 100 ticks.
module serial_command_frame_parser import sfp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  sfp_cmd_if.sink             cmd,
  sfp_res_if.source           result,
  input  logic                cfg_we,
  input  logic [TimeoutW-1:0] cfg_data
);

  logic [TimeoutW-1:0] idle_timeout_ticks;
  sfp_state_t          state;
  sfp_state_t          state_next;
  sfp_result_t         step_result;
  sfp_result_t         res;
  logic                res_valid;
  logic                accept;

  assign cmd.ready = !res_valid || result.ready;
  assign accept = cmd.valid && cmd.ready;

  sfp_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .state             (state),
    .opcode            (cmd.opcode),
    .rx_byte           (cmd.rx_byte),
    .idle_timeout_ticks(idle_timeout_ticks),
    .state_next        (state_next),
    .result            (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_result;
    end
  end

  assign result.valid = res_valid;
  assign result.event_res = res.event_res;
  assign result.field_index = res.field_index;
  assign result.char_position = res.char_position;
  assign result.char_value = res.char_value;

endmodule

### design/sfp_core.sv
// Next-state and event logic of the frame parser for one beat.
module sfp_core import sfp_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  sfp_state_t          state,
  input  logic                opcode,
  input  logic [ByteW-1:0]    rx_byte,
  input  logic [TimeoutW-1:0] idle_timeout_ticks,
  output sfp_state_t          state_next,
  output sfp_result_t         result
);

  localparam logic [CountW-1:0] Limit = CountW'(BUFFER_DEPTH);

  always_comb begin
    state_next = state;
    result = '{event_res: EV_NONE, field_index: '0, char_position: '0, char_value: '0};
    if (opcode == OP_TICK) begin
      if (state.timeout_left != '0) begin
        state_next.timeout_left = state.timeout_left - TimeoutW'(1);
      end else if (state.in_packet) begin
        result.event_res = EV_TIMEOUT;
        result.field_index = state.current_field;
        result.char_position = state.char_count;
        state_next = '0;
      end
    end else if (!state.in_packet) begin
      if (rx_byte == CHAR_COLON) begin
        state_next.in_packet = 1'b1;
        state_next.current_field = '0;
        state_next.char_count = '0;
        state_next.timeout_left = idle_timeout_ticks;
        result.event_res = EV_START;
      end else begin
        result.event_res = EV_IGNORED;
      end
    end else if (rx_byte == CHAR_BANG || state.char_count >= Limit) begin
      result.event_res = EV_DONE;
      result.field_index = state.current_field;
      result.char_position = state.char_count;
      state_next = '0;
    end else if (rx_byte == CHAR_COMMA) begin
      result.event_res = EV_FIELD;
      result.field_index = state.current_field;
      result.char_position = state.char_count;
      state_next.timeout_left = idle_timeout_ticks;
      state_next.char_count = '0;
      if (state.current_field < FIELD_DATA) begin
        state_next.current_field = state.current_field + FieldW'(1);
      end else begin
        state_next.current_field = FIELD_DATA;
      end
    end else if (rx_byte == CHAR_COLON) begin
      result.event_res = EV_IGNORED;
    end else begin
      result.event_res = EV_CHAR;
      result.field_index = state.current_field;
      result.char_position = state.char_count;
      result.char_value = rx_byte;
      state_next.timeout_left = idle_timeout_ticks;
      state_next.char_count = state.char_count + CountW'(1);
    end
  end

endmodule

### design/sfp_checker.sv
// Port-level checker of the frame parser and its bind statement.
`include "assert_macros.svh"

module sfp_checker import sfp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] event_res,
  input logic [1:0] field_index,
  input logic [8:0] char_position,
  input logic [7:0] char_value
);

  `SFP_ASSERT_NEXT(a_accept_gives_result, clk, rst,
    cmd_valid && cmd_ready, res_valid,
    "accepted beat did not produce a result")
  `SFP_ASSERT_NEXT(a_stall_holds, clk, rst,
    res_valid && !res_ready,
    res_valid && $stable(event_res) && $stable(char_position),
    "stalled result changed")
  `SFP_ASSERT_NOW(a_empty_ready, clk, rst,
    !res_valid, cmd_ready,
    "cmd not ready while result register is empty")
  `SFP_ASSERT_NOW(a_char_value_zero, clk, rst,
    res_valid && event_res != EV_CHAR, char_value == 8'd0,
    "char value set on a non-character event")
  `SFP_ASSERT_NOW(a_plain_event_zero, clk, rst,
    res_valid && (event_res == EV_NONE || event_res == EV_START || event_res == EV_IGNORED),
    field_index == 2'd0 && char_position == 9'd0,
    "field or position set on a plain event")

endmodule

bind serial_command_frame_parser sfp_checker u_sfp_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .event_res    (result.event_res),
  .field_index  (result.field_index),
  .char_position(result.char_position),
  .char_value   (result.char_value)
);

### bench/serial_command_frame_parser_tb.sv
// Self-checking testbench for the serial command frame parser: directed table plus random frames.
module serial_command_frame_parser_tb;
  import sfp_pkg::*;

  localparam int unsigned DEPTH = BUFFER_DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    opcode_t             op;
    logic [ByteW-1:0]    data;
    logic [TimeoutW-1:0] cfg_val;
    logic                checked;
    sfp_result_t         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_we;
  logic [TimeoutW-1:0] cfg_data;

  sfp_cmd_if cmd_ch ();
  sfp_res_if res_ch ();

  serial_command_frame_parser #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .result(res_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Parser state as the testbench expects it to be.
  logic                in_frame = 1'b0;
  logic [FieldW-1:0]   field_now = '0;
  logic [CountW-1:0]   chars_in_field = '0;
  logic [TimeoutW-1:0] ticks_left = '0;
  logic [TimeoutW-1:0] idle_ticks = TIMEOUT_RESET;

  sfp_result_t pending_events[$];
  logic        row_checked = 1'b0;
  sfp_result_t row_want = '0;
  int snd_idle = 16;
  int rcv_idle = 73;
  int err_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int timeouts_seen = 0;
  int limit_closes = 0;
  int stall_cycles = 0;

  function automatic sfp_result_t ev(input event_t e, input int f, input int p, input int c);
    sfp_result_t r;
    r.event_res = e;
    r.field_index = FieldW'(f);
    r.char_position = CountW'(p);
    r.char_value = ByteW'(c);
    return r;
  endfunction

  function automatic void close_frame();
    in_frame = 1'b0;
    field_now = '0;
    chars_in_field = '0;
    ticks_left = '0;
  endfunction

  function automatic sfp_result_t deframe(input opcode_t op, input logic [ByteW-1:0] b);
    sfp_result_t r;
    r = ev(EV_NONE, 0, 0, 0);
    if (op == OP_TICK) begin
      if (ticks_left != 0) begin
        ticks_left = ticks_left - 1'b1;
      end else if (in_frame) begin
        r = ev(EV_TIMEOUT, field_now, chars_in_field, 0);
        timeouts_seen++;
        close_frame();
      end
    end else if (!in_frame) begin
      if (b == CHAR_COLON) begin
        in_frame = 1'b1;
        field_now = '0;
        chars_in_field = '0;
        ticks_left = idle_ticks;
        r = ev(EV_START, 0, 0, 0);
      end else begin
        r = ev(EV_IGNORED, 0, 0, 0);
      end
    end else if (b == CHAR_BANG || chars_in_field >= DEPTH) begin
      if (chars_in_field >= DEPTH) limit_closes++;
      r = ev(EV_DONE, field_now, chars_in_field, 0);
      close_frame();
    end else if (b == CHAR_COMMA) begin
      ticks_left = idle_ticks;
      r = ev(EV_FIELD, field_now, chars_in_field, 0);
      if (field_now != FIELD_DATA) field_now = field_now + 1'b1;
      chars_in_field = '0;
    end else if (b == CHAR_COLON) begin
      r = ev(EV_IGNORED, 0, 0, 0);
    end else begin
      ticks_left = idle_ticks;
      r = ev(EV_CHAR, field_now, chars_in_field, b);
      chars_in_field = chars_in_field + 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk) begin
    sfp_result_t pred;
    sfp_result_t got;
    sfp_result_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        pred = deframe(opcode_t'(cmd_ch.opcode), cmd_ch.rx_byte);
        pending_events.push_back(row_checked ? row_want : pred);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.event_res = event_t'(res_ch.event_res);
        got.field_index = res_ch.field_index;
        got.char_position = res_ch.char_position;
        got.char_value = res_ch.char_value;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("result beat with event %0d arrived unexpectedly",
                                    got.event_res));
        end else begin
          want = pending_events.pop_front();
          if (got.event_res !== want.event_res)
            report_mismatch($sformatf("result %0d event_res got %0d expected %0d",
                                      results_checked, got.event_res, want.event_res));
          if (got.field_index !== want.field_index)
            report_mismatch($sformatf("result %0d field_index got %0d expected %0d",
                                      results_checked, got.field_index, want.field_index));
          if (got.char_position !== want.char_position)
            report_mismatch($sformatf("result %0d char_position got %0d expected %0d",
                                      results_checked, got.char_position,
                                      want.char_position));
          if (got.char_value !== want.char_value)
            report_mismatch($sformatf("result %0d char_value got %0h expected %0h",
                                      results_checked, got.char_value, want.char_value));
        end
        results_checked++;
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(input opcode_t op, input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.rx_byte <= b;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_events.size() != 0);
  endtask

  task automatic write_timeout(input logic [TimeoutW-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    idle_ticks = v;
  endtask

  task automatic tick_burst(input int n);
    for (int i = 0; i < n; i++) send_beat(OP_TICK, ByteW'($urandom_range(0, 255)));
  endtask

  // A frame with random content; long_fld selects a field that is filled up
  // to the buffer limit, or is negative for an ordinary short frame.
  task automatic send_frame(input int long_fld);
    int n;
    logic [ByteW-1:0] b;
    send_beat(OP_BYTE, CHAR_COLON);
    for (int f = 0; f < 3; f++) begin
      n = (f == long_fld) ? DEPTH : $urandom_range(0, (f == 2) ? 8 : 4);
      for (int k = 0; k < n; k++) begin
        b = ByteW'($urandom_range(0, 255));
        if (long_fld >= 0) begin
          if (b == CHAR_COLON || b == CHAR_BANG || b == CHAR_COMMA) b = "a";
        end else if ($urandom_range(0, 9) == 0) begin
          tick_burst($urandom_range(1, 3));
        end else if ($urandom_range(0, 19) == 0) begin
          b = CHAR_COLON;
        end else if (f == 2 && $urandom_range(0, 7) == 0) begin
          b = CHAR_COMMA;
        end
        send_beat(OP_BYTE, b);
      end
      if (f == long_fld) begin
        send_beat(OP_BYTE, ByteW'($urandom_range(0, 255)));
        return;
      end
      if (f < 2) send_beat(OP_BYTE, CHAR_COMMA);
    end
    if ($urandom_range(0, 7) != 0) send_beat(OP_BYTE, CHAR_BANG);
  endtask

  task automatic send_random_chunk();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) begin
      send_frame(-1);
    end else if (r == 6) begin
      repeat ($urandom_range(1, 5))
        send_beat(opcode_t'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255)));
    end else if (r == 7) begin
      tick_burst($urandom_range(1, (idle_ticks > 37) ? 40 : idle_ticks + 3));
    end else if (r == 8) begin
      send_beat(OP_BYTE, CHAR_COLON);
      repeat ($urandom_range(1, 6)) send_beat(OP_BYTE, ByteW'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 3) == 0) begin
      drain_results();
    end else begin
      send_frame(-1);
    end
  endtask

  initial begin
    stim_row_t steps[$];
    int budget;
    int long_fld;
    int phase_start;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_BYTE;
    cmd_ch.rx_byte = '0;
    cfg_we = 1'b0;
    cfg_data = '0;

    steps.push_back('{ROW_BEAT, OP_TICK, 8'h00, 10'd0, 1'b1, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, "x", 10'd0, 1'b1, ev(EV_IGNORED, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, 8'hFF, 10'd0, 1'b1, ev(EV_IGNORED, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COMMA, 10'd0, 1'b1, ev(EV_IGNORED, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COLON, 10'd0, 1'b1, ev(EV_START, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_BANG, 10'd0, 1'b1, ev(EV_DONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COLON, 10'd0, 1'b1, ev(EV_START, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, "A", 10'd0, 1'b1, ev(EV_CHAR, 0, 0, "A")});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COLON, 10'd0, 1'b1, ev(EV_IGNORED, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, 8'hFF, 10'd0, 1'b1, ev(EV_CHAR, 0, 1, 8'hFF)});
    steps.push_back('{ROW_BEAT, OP_TICK, 8'hA5, 10'd0, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COMMA, 10'd0, 1'b1, ev(EV_FIELD, 0, 2, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, 8'h00, 10'd0, 1'b1, ev(EV_CHAR, 1, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COMMA, 10'd0, 1'b1, ev(EV_FIELD, 1, 1, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, "d", 10'd0, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COMMA, 10'd0, 1'b1, ev(EV_FIELD, 2, 1, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, "e", 10'd0, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_BANG, 10'd0, 1'b1, ev(EV_DONE, 2, 1, 0)});
    steps.push_back('{ROW_CFG, OP_BYTE, 8'h00, 10'd0, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COLON, 10'd0, 1'b1, ev(EV_START, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, "q", 10'd0, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_TICK, 8'h5A, 10'd0, 1'b1, ev(EV_TIMEOUT, 0, 1, 0)});
    steps.push_back('{ROW_BEAT, OP_TICK, 8'h00, 10'd0, 1'b1, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_CFG, OP_BYTE, 8'h00, 10'd1, 1'b0, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_BYTE, CHAR_COLON, 10'd0, 1'b1, ev(EV_START, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_TICK, 8'h00, 10'd0, 1'b1, ev(EV_NONE, 0, 0, 0)});
    steps.push_back('{ROW_BEAT, OP_TICK, 8'hFF, 10'd0, 1'b1, ev(EV_TIMEOUT, 0, 0, 0)});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) begin
        write_timeout(steps[i].cfg_val);
      end else begin
        row_checked = steps[i].checked;
        row_want = steps[i].want;
        send_beat(steps[i].op, steps[i].data);
      end
    end
    drain_results();
    row_checked = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_timeout('0);
          budget = 240;
          long_fld = -1;
        end
        1: begin
          write_timeout(10'd1023);
          budget = 380;
          long_fld = 0;
        end
        2: begin
          snd_idle = 73;
          rcv_idle = 16;
          write_timeout(10'd1);
          budget = 240;
          long_fld = -1;
        end
        3: begin
          write_timeout(TimeoutW'($urandom_range(2, 12)));
          budget = 380;
          long_fld = 2;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          write_timeout(TimeoutW'($urandom_range(3, 40)));
          budget = 280;
          long_fld = 1;
        end
      endcase
      phase_start = beats_sent;
      if (long_fld >= 0) send_frame(long_fld);
      while (beats_sent - phase_start < budget) send_random_chunk();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_events.size()));
    $display("Sent %0d beats under five timeout settings and three stall patterns,",
             beats_sent);
    $display("checked %0d results, seeing %0d timeouts and %0d buffer-limit closes.",
             results_checked, timeouts_seen, limit_closes);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/sfp_pkg.sv
design/sfp_cmd_if.sv
design/sfp_res_if.sv
design/sfp_core.sv
design/serial_command_frame_parser.sv
design/sfp_checker.sv
bench/serial_command_frame_parser_tb.sv
